@@ rtl/sidq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidq_pkg
// Shared widths, request and status codes, and control types for the
// signed index deque.
// ----------------------------------------------------------------------------
package sidq_pkg;

  localparam int DATA_W          = 32;
  localparam int CMD_W           = 3;
  localparam int POS_W           = 5;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 5;
  // A position reaches entries 0 to 15 of either bank.
  localparam int IDX_IN_W        = POS_W - 1;
  localparam int DEF_BANK_DEPTH  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_FIND       = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_MISS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIND
  } state_t;

  // Operations applied to one bank in a cycle; at most one is set.
  typedef struct packed {
    logic append;
    logic insert;
    logic remove;
    logic clear;
    logic find;
  } bank_cmd_t;

endpackage
`default_nettype wire

@@ rtl/sidq_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidq_req_if
// Request channel of the signed index deque: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface sidq_req_if
  import sidq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, output command, output value, output position,
                  input ready);
  modport sink (input valid, input command, input value, input position,
                output ready);
endinterface
`default_nettype wire

@@ rtl/sidq_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidq_rsp_if
// Response channel of the signed index deque: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface sidq_rsp_if
  import sidq_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [POS_W-1:0]   found_position;
  logic [COUNT_W-1:0]        front_count;
  logic [COUNT_W-1:0]        back_count;

  modport source (output valid, output status, output found_position,
                  output front_count, output back_count, input ready);
  modport sink (input valid, input status, input found_position,
                input front_count, input back_count, output ready);
endinterface
`default_nettype wire

@@ rtl/sidq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidq_cell
// One bank entry: holds a word, loads, shifts from a neighbor, and
// registers a compare against the search value.
// ----------------------------------------------------------------------------
module sidq_cell
  import sidq_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_op_t          op,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [DATA_W-1:0] lower,
  input  wire logic [DATA_W-1:0] upper,
  input  wire logic              find,
  output logic      [DATA_W-1:0] data,
  output logic                   hit
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LOAD:       data <= value;
      CELL_FROM_LOWER: data <= lower;
      CELL_FROM_UPPER: data <= upper;
      default:         data <= data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (find) begin
      hit <= (data == value);
    end
  end

endmodule
`default_nettype wire

@@ rtl/sidq_bank.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidq_bank
// One bank: a row of cells with its fill count. Insert shifts the cells
// above the position outward, remove shifts them inward.
// ----------------------------------------------------------------------------
module sidq_bank
  import sidq_pkg::*;
#(
  parameter int BANK_DEPTH = DEF_BANK_DEPTH,
  parameter int FILL_W     = $clog2(BANK_DEPTH + 1)
)(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bank_cmd_t           cmd,
  input  wire logic [IDX_IN_W-1:0] idx,
  input  wire logic [DATA_W-1:0]   value,
  output logic      [FILL_W-1:0]   fill,
  output logic      [FILL_W-1:0]   fill_next,
  output logic  [BANK_DEPTH-1:0]   hit
);

  localparam int CMP_W = (FILL_W > IDX_IN_W) ? FILL_W : IDX_IN_W;

  logic [DATA_W-1:0] data [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] cell_hit;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] idx_ext;

  assign fill_ext = CMP_W'(fill);
  assign idx_ext  = CMP_W'(idx);

  always_comb begin
    fill_next = fill;
    if (cmd.clear) begin
      fill_next = '0;
    end else if (cmd.append || cmd.insert) begin
      fill_next = fill + FILL_W'(1);
    end else if (cmd.remove) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  for (genvar i = 0; i < BANK_DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CI = CMP_W'(i);
    cell_op_t          op;
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;

    always_comb begin
      if (cmd.append && (CI == fill_ext)) begin
        op = CELL_LOAD;
      end else if (cmd.insert && (CI == idx_ext)) begin
        op = CELL_LOAD;
      end else if (cmd.insert && (CI > idx_ext)) begin
        op = CELL_FROM_LOWER;
      end else if (cmd.remove && (CI >= idx_ext) && (i < BANK_DEPTH - 1)) begin
        op = CELL_FROM_UPPER;
      end else begin
        op = CELL_HOLD;
      end
    end

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_inner_lo
      assign lower = data[i-1];
    end
    if (i == BANK_DEPTH - 1) begin : g_last
      assign upper = data[i];
    end else begin : g_inner_hi
      assign upper = data[i+1];
    end

    sidq_cell u_cell (
      .clk   (clk),
      .op    (op),
      .value (value),
      .lower (lower),
      .upper (upper),
      .find  (cmd.find),
      .data  (data[i]),
      .hit   (cell_hit[i])
    );

    // Only occupied entries may match; the fill does not move during a find.
    assign hit[i] = cell_hit[i] && (CI < fill_ext);
  end

endmodule
`default_nettype wire

@@ rtl/signed_index_deque_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signed_index_deque_core
// Deque in two banks of cells addressed by a signed position.
// ----------------------------------------------------------------------------
// Push, insert, remove, clear and unused codes answer in the cycle after the
// request is taken; a find first registers each cell's compare, then picks the
// first match in the find state. One request per cycle unless the response is
// stalled; a find blocks requests in the find state. Reset clears both fill
// counts, the state machine and the response valid; the bank entries are not
// cleared and need no clearing pass.
module signed_index_deque_core
  import sidq_pkg::*;
#(
  parameter int BANK_DEPTH = DEF_BANK_DEPTH
)(
  input  wire logic clk,
  input  wire logic rst,
  sidq_req_if.sink   req,
  sidq_rsp_if.source rsp
);

  localparam int FILL_W = $clog2(BANK_DEPTH + 1);
  localparam int IDX_W  = $clog2(BANK_DEPTH);
  localparam int CMP_W  = (FILL_W > IDX_IN_W) ? FILL_W : IDX_IN_W;

  state_t state, state_next;

  bank_cmd_t front_cmd, back_cmd;
  logic [FILL_W-1:0] front_fill, front_fill_next;
  logic [FILL_W-1:0] back_fill, back_fill_next;
  logic [BANK_DEPTH-1:0] front_hit, back_hit;

  logic              accept;
  logic              neg;
  logic [IDX_IN_W-1:0] idx;
  logic [FILL_W-1:0] sel_fill;
  logic              idx_bad;
  logic              front_full, back_full, sel_full;
  status_t           cmd_status;
  logic              cmd_ok;

  logic [IDX_W-1:0]  front_k, back_k;
  logic              front_any, back_any;

  logic              out_valid;
  logic              load;
  status_t           load_status;
  logic [POS_W-1:0]  load_found;
  status_t           status;
  logic [POS_W-1:0]  found_position;
  logic [COUNT_W-1:0] front_count, back_count;

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // A negative position -k selects back entry k-1, which is the inverted low bits.
  assign neg      = req.position[POS_W-1];
  assign idx      = neg ? ~req.position[IDX_IN_W-1:0] : req.position[IDX_IN_W-1:0];
  assign sel_fill = neg ? back_fill : front_fill;
  assign idx_bad  = CMP_W'(idx) >= CMP_W'(sel_fill);

  assign front_full = front_fill == FILL_W'(BANK_DEPTH);
  assign back_full  = back_fill == FILL_W'(BANK_DEPTH);
  assign sel_full   = neg ? back_full : front_full;

  always_comb begin
    case (cmd_t'(req.command))
      CMD_PUSH_FRONT: cmd_status = front_full ? STAT_FULL : STAT_OK;
      CMD_PUSH_BACK:  cmd_status = back_full ? STAT_FULL : STAT_OK;
      CMD_INSERT:     cmd_status = idx_bad ? STAT_BADPOS : (sel_full ? STAT_FULL : STAT_OK);
      CMD_REMOVE:     cmd_status = idx_bad ? STAT_BADPOS : STAT_OK;
      default:        cmd_status = STAT_OK;
    endcase
  end
  assign cmd_ok = accept && (cmd_status == STAT_OK);

  always_comb begin
    front_cmd = '0;
    back_cmd  = '0;
    unique case (cmd_t'(req.command))
      CMD_PUSH_FRONT: front_cmd.append = cmd_ok;
      CMD_PUSH_BACK:  back_cmd.append  = cmd_ok;
      CMD_INSERT: begin
        front_cmd.insert = cmd_ok && !neg;
        back_cmd.insert  = cmd_ok && neg;
      end
      CMD_REMOVE: begin
        front_cmd.remove = cmd_ok && !neg;
        back_cmd.remove  = cmd_ok && neg;
      end
      CMD_CLEAR: begin
        front_cmd.clear = accept;
        back_cmd.clear  = accept;
      end
      CMD_FIND: begin
        front_cmd.find = accept;
        back_cmd.find  = accept;
      end
      default: ;
    endcase
  end

  sidq_bank #(
    .BANK_DEPTH (BANK_DEPTH),
    .FILL_W     (FILL_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (front_cmd),
    .idx       (idx),
    .value     (req.value),
    .fill      (front_fill),
    .fill_next (front_fill_next),
    .hit       (front_hit)
  );

  sidq_bank #(
    .BANK_DEPTH (BANK_DEPTH),
    .FILL_W     (FILL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .idx       (idx),
    .value     (req.value),
    .fill      (back_fill),
    .fill_next (back_fill_next),
    .hit       (back_hit)
  );

  // Lowest matching entry of each bank.
  always_comb begin
    front_k   = '0;
    back_k    = '0;
    front_any = 1'b0;
    back_any  = 1'b0;
    for (int i = BANK_DEPTH - 1; i >= 0; i--) begin
      if (front_hit[i]) begin
        front_k   = IDX_W'(i);
        front_any = 1'b1;
      end
      if (back_hit[i]) begin
        back_k   = IDX_W'(i);
        back_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    load        = 1'b0;
    load_status = cmd_status;
    load_found  = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(req.command) == CMD_FIND) begin
            state_next = ST_FIND;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_FIND: begin
        load       = 1'b1;
        state_next = ST_IDLE;
        if (back_any) begin
          // Back entry k sits at position -(k+1).
          load_status = STAT_OK;
          load_found  = ~POS_W'(back_k);
        end else if (front_any) begin
          load_status = STAT_OK;
          load_found  = POS_W'(front_k);
        end else begin
          load_status = STAT_MISS;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= load_status;
      found_position <= load_found;
      front_count    <= COUNT_W'(front_fill_next);
      back_count     <= COUNT_W'(back_fill_next);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = status;
  assign rsp.found_position = found_position;
  assign rsp.front_count    = front_count;
  assign rsp.back_count     = back_count;

endmodule
`default_nettype wire
